FILE: hw/rtl/slsel_pkg.sv
// Shared types and constants for the sprite line selector.
package slsel_pkg;

	localparam int ENTRIES_DEF      = 40;
	localparam int MAX_PER_LINE_DEF = 10;
	localparam int LINES_DEF        = 144;

	localparam int IDX_W   = 6;
	localparam int COORD_W = 8;

	// sprite Y is stored as screen line plus this offset
	localparam logic [COORD_W:0] Y_OFFSET     = 9'd16;
	localparam logic [COORD_W:0] SHORT_HEIGHT = 9'd8;
	localparam logic [COORD_W:0] TALL_HEIGHT  = 9'd16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [IDX_W-1:0]   entry_index;
		logic [COORD_W-1:0] y_pos;
		logic [COORD_W-1:0] x_pos;
		logic               tall;
		logic [COORD_W-1:0] line;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   sprite_index;
		logic [COORD_W-1:0] sprite_x;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
		logic               tall;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

FILE: hw/rtl/slsel_table.sv
// Sprite attribute table: one write port, one registered read port, per-entry valid bits.
module slsel_table #(
	parameter int ENTRIES = slsel_pkg::ENTRIES_DEF,
	parameter int AW      = slsel_pkg::IDX_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  slsel_pkg::entry_t wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output slsel_pkg::entry_t rd_data
);
	import slsel_pkg::*;

	entry_t             mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	entry_t             mem_s1;
	logic               vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// never-written entries read as zero
	assign rd_data = vld_s1 ? mem_s1 : '0;

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("table read and write in the same cycle");
	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(wr_addr)])
		else $error("valid bit not set after write");
	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !vld_q[rd_addr]) |=> (rd_data == '0))
		else $error("unwritten entry did not read as zero");
`endif

endmodule

FILE: hw/rtl/sprite_line_selector_unit.sv
// Top level of the sprite line selector: table, line scan, sorted hit list, result register.
//
//  channel | dir | payload | transfer when
//  req     | in  | req_t   | req_valid & !req_stall
//  rsp     | out | rsp_t   | rsp_valid & !rsp_stall
//
//  Write item: stored at the transfer edge, no result.
//  Query item: a scan of the table (one table read per cycle through the
//  single read port); the first result is loaded into the output register
//  after the scan, then one result per cycle while rsp is not stalled.
//  Reset clears the state machine, the table valid bits and the result valid flag.
//  req_stall is high while a query is scanning or emitting; the final result
//  may sit in the output register while the next item is taken.
module sprite_line_selector_unit #(
	parameter int ENTRIES      = slsel_pkg::ENTRIES_DEF,
	parameter int MAX_PER_LINE = slsel_pkg::MAX_PER_LINE_DEF,
	parameter int LINES        = slsel_pkg::LINES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  slsel_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output slsel_pkg::rsp_t rsp
);
	import slsel_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(MAX_PER_LINE + 1);
	localparam int PW = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

	state_t state_q, state_d;

	logic req_xfer;
	logic wr_en;
	logic rd_en;
	entry_t wr_data;
	entry_t rd_data;

	// scan control
	logic [AW-1:0]      rd_cnt_q;
	logic               issuing_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      idx_s1;
	logic               last_s1;
	logic [COORD_W-1:0] line_q;
	logic               line_ok_q;

	// sorted hit list
	logic [COORD_W-1:0] lx_q   [MAX_PER_LINE];
	logic [IDX_W-1:0]   lidx_q [MAX_PER_LINE];
	logic [CW-1:0]      count_q;
	logic [PW-1:0]      emit_q;
	logic [MAX_PER_LINE-1:0] gt;

	// on-line check of the entry coming out of the table
	logic [COORD_W:0] pos;
	logic [COORD_W:0] top;
	logic [COORD_W:0] bot;
	logic             hit;
	logic             ins;

	// result register
	logic out_valid_q;
	rsp_t out_q;
	logic load;
	rsp_t nxt;
	logic emit_last;

	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	// extra bit so a full 64-entry table still compares correctly
	assign wr_en     = req_xfer && (req.operation == OP_WRITE)
		&& ({1'b0, req.entry_index} < (IDX_W + 1)'(ENTRIES));
	assign rd_en     = (state_q == ST_SCAN) && issuing_q;
	assign wr_data   = '{y: req.y_pos, x: req.x_pos, tall: req.tall};

	slsel_table #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (req.entry_index[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_cnt_q),
		.rd_data (rd_data)
	);

	assign pos = {1'b0, line_q} + Y_OFFSET;
	assign top = {1'b0, rd_data.y};
	assign bot = top + (rd_data.tall ? TALL_HEIGHT : SHORT_HEIGHT);
	assign hit = line_ok_q && (top <= pos) && (pos < bot);
	// hits past the first MAX_PER_LINE in index order are dropped
	assign ins = rd_vld_s1 && hit && (count_q < CW'(MAX_PER_LINE));

	// gt is monotone over the sorted list; new entry goes after all equal X
	always_comb begin
		for (int k = 0; k < MAX_PER_LINE; k++) begin
			gt[k] = (CW'(k) < count_q) && (lx_q[k] > rd_data.x);
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			for (int k = 0; k < MAX_PER_LINE; k++) begin
				if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
					lx_q[k]   <= lx_q[(k > 0) ? k - 1 : 0];
					lidx_q[k] <= lidx_q[(k > 0) ? k - 1 : 0];
				end else if (gt[k] || (CW'(k) == count_q)) begin
					lx_q[k]   <= rd_data.x;
					lidx_q[k] <= IDX_W'(idx_s1);
				end
			end
		end
		if (req_xfer) begin
			line_q    <= req.line;
			line_ok_q <= (req.line < COORD_W'(LINES));
		end
		if (rd_en) begin
			idx_s1  <= rd_cnt_q;
			last_s1 <= (rd_cnt_q == AW'(ENTRIES - 1));
		end
		if (load) begin
			out_q <= nxt;
		end
	end

	// next result out of the sorted list
	always_comb begin
		emit_last = ((CW'(emit_q) + CW'(1)) == count_q);
		if (count_q == '0) begin
			nxt = '{found: 1'b0, sprite_index: '0, sprite_x: '0, last: 1'b1};
		end else begin
			nxt = '{found: 1'b1, sprite_index: lidx_q[emit_q],
				sprite_x: lx_q[emit_q], last: emit_last};
		end
	end

	assign load = (state_q == ST_EMIT) && (!out_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer && (req.operation == OP_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_vld_s1 && last_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load && nxt.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			issuing_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			count_q     <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (req_xfer && (req.operation == OP_QUERY)) begin
				rd_cnt_q  <= '0;
				issuing_q <= 1'b1;
				count_q   <= '0;
				emit_q    <= '0;
			end else begin
				if (rd_en) begin
					if (rd_cnt_q == AW'(ENTRIES - 1)) begin
						issuing_q <= 1'b0;
					end else begin
						rd_cnt_q <= rd_cnt_q + AW'(1);
					end
				end
				if (ins) begin
					count_q <= count_q + CW'(1);
				end
				if (load && !nxt.last) begin
					emit_q <= emit_q + PW'(1);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PER_LINE))
		else $error("hit count above limit");
	a_miss_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |-> rsp.last)
		else $error("not-found result without last");
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |->
		({1'b0, rsp.sprite_index} < (IDX_W + 1)'(ENTRIES)))
		else $error("result index out of table range");
	a_scan_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rd_vld_s1 && last_s1) |=> (state_q == ST_EMIT))
		else $error("scan end did not start emit");
`endif

endmodule

FILE: tb/sv/tb.sv
// Testbench for sprite_line_selector_unit: directed and random table writes and line queries.
`timescale 1ns / 1ps

module tb;
	import slsel_pkg::*;

	localparam int NUM_ENTRIES = ENTRIES_DEF;
	localparam int HIT_LIMIT   = MAX_PER_LINE_DEF;
	localparam int NUM_LINES   = LINES_DEF;
	localparam int LINE_OFS    = 16;   // raw Y is screen line plus this
	localparam int H_SHORT     = 8;
	localparam int H_TALL      = 16;
	// one scan pass plus the result register, with margin
	localparam int SETTLE_CYC  = NUM_ENTRIES + 2 + HIT_LIMIT + 20;
	localparam int DRAIN_CAP   = 50000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// idle percentages for the two channels, changed per test phase
	int snd_idle_pct = 15;
	int rcv_idle_pct = 67;

	// receiver hold-off: rsp_stall forced high until cycle_cnt reaches hold_end
	int cycle_cnt = 0;
	int hold_end = 0;

	int err_cnt = 0;

	// predicted table contents
	logic [COORD_W-1:0] attr_y    [NUM_ENTRIES];
	logic [COORD_W-1:0] attr_x    [NUM_ENTRIES];
	logic               attr_tall [NUM_ENTRIES];

	// results still owed by the block, oldest first
	rsp_t line_hits_q[$];

	sprite_line_selector_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// receiver stall: random idling plus the long hold-off window
	always @(posedge clk) begin
		rsp_stall <= (cycle_cnt < hold_end) || ($urandom_range(99) < rcv_idle_pct);
	end

	task automatic note_mismatch(string what, rsp_t exp, rsp_t got);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("[%0t] %s: exp found=%0d idx=%0d x=%0d last=%0d, got found=%0d idx=%0d x=%0d last=%0d",
				$realtime, what, exp.found, exp.sprite_index, exp.sprite_x, exp.last,
				got.found, got.sprite_index, got.sprite_x, got.last);
		end
	endtask

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin : rsp_check
		rsp_t exp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (line_hits_q.size() == 0) begin
				note_mismatch("unexpected result", '0, rsp);
			end else begin
				exp = line_hits_q.pop_front();
				if (rsp.found !== exp.found || rsp.sprite_index !== exp.sprite_index ||
				    rsp.sprite_x !== exp.sprite_x || rsp.last !== exp.last) begin
					note_mismatch("result mismatch", exp, rsp);
				end
			end
		end
	end

	// Scan the predicted table for one line, keep the first hits in index
	// order, then order them by X (stable, so equal X stays in index order).
	task automatic select_line_sprites(logic [COORD_W-1:0] ln);
		int hits[$];
		int pos, top, height, cur, k;
		rsp_t r;
		pos = int'(ln) + LINE_OFS;
		if (int'(ln) < NUM_LINES) begin
			for (int i = 0; i < NUM_ENTRIES && hits.size() < HIT_LIMIT; i++) begin
				top = int'(attr_y[i]);
				height = attr_tall[i] ? H_TALL : H_SHORT;
				if (top <= pos && pos < top + height)
					hits.push_back(i);
			end
		end
		if (hits.size() == 0) begin
			r = '0;
			r.last = 1'b1;
			line_hits_q.push_back(r);
		end else begin
			for (int i = 1; i < hits.size(); i++) begin
				cur = hits[i];
				k = i;
				while (k > 0 && attr_x[hits[k-1]] > attr_x[cur]) begin
					hits[k] = hits[k-1];
					k--;
				end
				hits[k] = cur;
			end
			foreach (hits[j]) begin
				r.found = 1'b1;
				r.sprite_index = IDX_W'(hits[j]);
				r.sprite_x = attr_x[hits[j]];
				r.last = (j == hits.size() - 1);
				line_hits_q.push_back(r);
			end
		end
	endtask

	// One request transfer. Valid stays high on return so back-to-back items
	// never drop it; the next call or drain_block lowers it if needed.
	task automatic send_item(req_t it);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall);
		if (it.operation == OP_WRITE) begin
			if (int'(it.entry_index) < NUM_ENTRIES) begin
				attr_y[it.entry_index] = it.y_pos;
				attr_x[it.entry_index] = it.x_pos;
				attr_tall[it.entry_index] = it.tall;
			end
		end else begin
			select_line_sprites(it.line);
		end
	endtask

	task automatic put_entry(int idx, int y, int x, bit is_tall);
		req_t it;
		it.operation = OP_WRITE;
		it.entry_index = idx[IDX_W-1:0];
		it.y_pos = y[COORD_W-1:0];
		it.x_pos = x[COORD_W-1:0];
		it.tall = is_tall;
		it.line = COORD_W'($urandom);   // ignored by a write
		send_item(it);
	endtask

	task automatic ask_line(int ln);
		req_t it;
		it = req_t'($urandom);          // unused fields get junk
		it.operation = OP_QUERY;
		it.line = ln[COORD_W-1:0];
		send_item(it);
	endtask

	// Stop offering and wait for every owed result, then let the block settle.
	task automatic drain_block();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		while (line_hits_q.size() != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Fresh table is all zero Y: nothing reaches any visible line.
	task automatic test_reset_table();
		ask_line(0);
	endtask

	// Index and line limits, all-ones fields, ignored writes.
	task automatic test_write_bounds();
		put_entry(NUM_ENTRIES - 1, 159, 255, 1'b1);
		put_entry(NUM_ENTRIES, 16, 1, 1'b0);     // out of range, dropped
		put_entry(63, 16, 1, 1'b1);              // all index bits set, dropped
		ask_line(NUM_LINES - 1);                 // hits only the last entry
		ask_line(NUM_LINES);                     // out of range line
		ask_line(255);
	endtask

	// Short and tall sprite edges; equal X keeps index order.
	task automatic test_height_edges();
		put_entry(0, 20, 0, 1'b0);   // lines 4..11
		put_entry(1, 20, 0, 1'b1);   // lines 4..19
		ask_line(3);
		ask_line(4);
		ask_line(11);
		ask_line(12);
		ask_line(19);
	endtask

	// Eleven sprites on one line: the eleventh in index order is dropped,
	// the rest come back ordered by X with ties.
	task automatic test_overflow();
		int xs[11] = '{200, 5, 5, 0, 255, 5, 100, 0, 7, 9, 1};
		for (int i = 0; i < 11; i++)
			put_entry(2 + i, 60, xs[i], i[0]);
		ask_line(44);
	endtask

	// Random items clustered around a moving band of lines so that queries
	// see several hits and sometimes overflow; a fraction is off-range noise.
	task automatic test_random(int snd_pct, int rcv_pct, int n_items);
		int center, ln, y;
		req_t it;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		center = $urandom_range(24, 150);
		for (int n = 0; n < n_items; n++) begin
			if (n % 30 == 29)
				center = $urandom_range(24, 150);
			it = req_t'($urandom);
			if ($urandom_range(99) < 55) begin
				it.operation = OP_WRITE;
				if ($urandom_range(99) < 8)
					it.entry_index = IDX_W'($urandom_range(NUM_ENTRIES, 63));
				else
					it.entry_index = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
				if ($urandom_range(99) < 20) begin
					it.y_pos = COORD_W'($urandom_range(0, 255));
				end else begin
					y = center + $urandom_range(0, 24) - 12;
					it.y_pos = y[COORD_W-1:0];
				end
				if ($urandom_range(99) < 30)
					it.x_pos = COORD_W'($urandom_range(0, 3));
			end else begin
				it.operation = OP_QUERY;
				if ($urandom_range(99) < 10) begin
					it.line = COORD_W'($urandom_range(NUM_LINES, 255));
				end else begin
					ln = center - LINE_OFS + $urandom_range(0, 20) - 4;
					if (ln < 0 || ln >= NUM_LINES)
						ln = $urandom_range(0, NUM_LINES - 1);
					it.line = ln[COORD_W-1:0];
				end
			end
			send_item(it);
		end
	endtask

	// Receiver holds off for a long stretch while queries keep coming, so the
	// result register fills and the block stalls its request side.
	task automatic test_backpressure();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_end <= cycle_cnt + 600;
		for (int i = 0; i < 8; i++)
			ask_line(44);
	endtask

	initial begin
		foreach (attr_y[i]) begin
			attr_y[i] = '0;
			attr_x[i] = '0;
			attr_tall[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_table();
		test_write_bounds();
		test_height_edges();
		test_overflow();
		test_random(15, 67, 82);
		test_backpressure();
		test_random(67, 15, 82);
		test_random(0, 0, 82);
		drain_block();

		if (line_hits_q.size() != 0) begin
			$display("%0d expected results never arrived", line_hits_q.size());
			err_cnt += line_hits_q.size();
		end
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// run limit: far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/slsel_pkg.sv
hw/rtl/slsel_table.sv
hw/rtl/sprite_line_selector_unit.sv
tb/sv/tb.sv
